FILE: design/stbe_pkg.sv
package stbe_pkg;

   // defaults and fixed limits
   localparam int NUM_PORTS_DEF = 8;
   localparam int MAX_RESULTS   = 8;
   localparam int CSR_IDX_W     = 2;
   localparam int EMIT_CNT_W    = 4;

   // item kinds
   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_CONFIG = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BRIDGE_ID     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_COUNT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_COST     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_PRIORITY = 2'd3;

   // register reset values
   localparam logic [63:0] RST_BRIDGE_ID     = 64'd0;
   localparam logic [3:0]  RST_PORT_COUNT    = 4'd8;
   localparam logic [15:0] RST_PORT_COST     = 16'd1;
   localparam logic [7:0]  RST_PORT_PRIORITY = 8'd128;

   // priority vector, most significant field first so a plain compare is lexicographic
   typedef struct packed {
      logic [63:0] root_id;
      logic [31:0] cost;
      logic [63:0] bridge_id;
      logic [15:0] peer_id;
   } vec_type;

   typedef struct packed {
      logic [2:0]  port_index;
      logic [63:0] root_id;
      logic [31:0] root_cost;
      logic [63:0] bridge_id;
      logic [15:0] port_id;
      logic        last;
   } tx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START_WR,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_CFG_RD,
      ST_CFG_CHK,
      ST_ELECT_RD,
      ST_ELECT_CHK,
      ST_ROOT_SET,
      ST_UPD_RD,
      ST_UPD_CHK,
      ST_FINISH
   } state_type;

endpackage

FILE: design/stbe_if.sv
interface stbe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [2:0]  port_index;
   logic [63:0] rx_root_id;
   logic [31:0] rx_root_cost;
   logic [63:0] rx_bridge_id;
   logic [15:0] rx_port_id;

   modport source (output valid, kind, port_index, rx_root_id, rx_root_cost,
                   rx_bridge_id, rx_port_id, input ready);
   modport sink (input valid, kind, port_index, rx_root_id, rx_root_cost,
                 rx_bridge_id, rx_port_id, output ready);
endinterface

interface stbe_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  tx_port_index;
   logic [63:0] tx_root_id;
   logic [31:0] tx_root_cost;
   logic [63:0] tx_bridge_id;
   logic [15:0] tx_port_id;
   logic        last;

   modport source (output valid, tx_port_index, tx_root_id, tx_root_cost,
                   tx_bridge_id, tx_port_id, last, input ready);
   modport sink (input valid, tx_port_index, tx_root_id, tx_root_cost,
                 tx_bridge_id, tx_port_id, last, output ready);
endinterface

FILE: design/stbe_vec_cmp.sv
module stbe_vec_cmp (
   input  stbe_pkg::vec_type a,
   input  stbe_pkg::vec_type b,
   output logic              a_better
);
   import stbe_pkg::*;

   // root, cost, bridge, port in that order; smaller wins
   assign a_better = (a < b);

endmodule

FILE: design/spanning_tree_bpdu_engine_top.sv
// Spanning-tree config message engine for one bridge.
// req_chan carries one item per beat: a start, a hello tick or a received
// config vector with its port. rsp_chan returns the configs to send, at
// most one beat per port in port order, last set on the final beat of the item.
// csr_* writes bridge id, port count, port cost and port priority; write
// only while the block is idle.
// One item is handled at a time; req_chan.ready is high only when idle.
// All port vectors sit in one single-port memory with registered read. The
// tick and config walks visit each port with a read state, then a
// check/write state; a start writes each port in use directly. A config that
// the stored vector does not beat walks once to elect, then once to update
// and send.
// A result is held one beat in a pending stage so last can be set; a
// further output register decouples the receiver. When rsp_chan stalls
// with both full, the port walk holds until the beat is taken.
// Synchronous reset clears control state and loads the register defaults;
// port vectors are undefined until the first start item writes them.
module spanning_tree_bpdu_engine_top (
   input  logic                           clock,
   input  logic                           reset,
   stbe_req_if.sink                       req_chan,
   stbe_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [stbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                    csr_wdata
);
   import stbe_pkg::*;

   // port fields on both channels are three bits wide
   localparam int NUM_PORTS = NUM_PORTS_DEF;
   localparam int IW  = $clog2(NUM_PORTS);
   localparam int PIW = $clog2(NUM_PORTS + 1);

   // configuration registers
   logic [63:0] bridge_id_ff;
   logic [3:0]  port_count_ff;
   logic [15:0] port_cost_ff;
   logic [7:0]  port_priority_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bridge_id_ff     <= RST_BRIDGE_ID;
         port_count_ff    <= RST_PORT_COUNT;
         port_cost_ff     <= RST_PORT_COST;
         port_priority_ff <= RST_PORT_PRIORITY;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BRIDGE_ID:     bridge_id_ff     <= csr_wdata;
            CSR_PORT_COUNT:    port_count_ff    <= csr_wdata[3:0];
            CSR_PORT_COST:     port_cost_ff     <= csr_wdata[15:0];
            CSR_PORT_PRIORITY: port_priority_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // bridge state and sequencer registers
   state_type                state_ff, state_in;
   logic [PIW-1:0]           idx_ff, idx_in;
   logic [1:0]               kind_ff;
   vec_type                  rx_ff;
   logic [2:0]               rx_port_ff;
   logic [63:0]              root_id_ff;
   logic [31:0]              root_cost_ff;
   logic                     root_port_valid_ff;
   logic                     hello_ff;
   logic                     found_ff;
   vec_type                  best_ff;
   logic [EMIT_CNT_W-1:0]    emit_cnt_ff;
   logic                     pend_valid_ff;
   tx_type                   pend_ff;
   logic                     out_valid_ff;
   tx_type                   out_ff;

   // port vector memory
   vec_type                  port_mem [NUM_PORTS];
   vec_type                  rd_data_ff;
   logic [IW-1:0]            mem_addr;
   logic                     wr_en;
   vec_type                  wr_data;

   // combinational helpers
   logic [PIW-1:0]           cnt;
   logic                     req_beat;
   logic                     may_send;
   logic [7:0]               cur_num;
   logic [15:0]              own_id;
   logic                     designated;
   vec_type                  cmp_b;
   logic                     rd_better;
   logic                     upd_take;
   logic [32:0]              cost_sum;
   logic [31:0]              cost_sat;
   logic                     want_emit;
   logic                     do_emit;
   logic                     out_free;
   logic                     stall;
   logic                     push_out;
   tx_type                   emit_data;

   assign cnt      = (32'(port_count_ff) > NUM_PORTS) ? PIW'(NUM_PORTS) : PIW'(port_count_ff);
   assign req_beat = req_chan.valid && req_chan.ready;
   assign may_send = (root_id_ff == bridge_id_ff) || root_port_valid_ff;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   // current port number and its own identifier
   always_comb begin
      if (state_ff == ST_CFG_RD || state_ff == ST_CFG_CHK) begin
         cur_num = 8'(rx_port_ff);
      end else begin
         cur_num = 8'(idx_ff);
      end
   end
   assign own_id     = {port_priority_ff, cur_num + 8'd1};
   assign mem_addr   = (state_ff == ST_CFG_RD || state_ff == ST_CFG_CHK) ?
                       IW'(rx_port_ff) : idx_ff[IW-1:0];
   assign designated = (rd_data_ff.bridge_id == bridge_id_ff) &&
                       (rd_data_ff.peer_id == own_id);

   // shared vector comparator: stored entry against received or best so far
   assign cmp_b = (state_ff == ST_CFG_CHK) ? rx_ff : best_ff;

   stbe_vec_cmp u_cmp (
      .a        (rd_data_ff),
      .b        (cmp_b),
      .a_better (rd_better)
   );

   assign upd_take = root_cost_ff < rd_data_ff.cost;
   assign cost_sum = {1'b0, best_ff.cost} + 33'(port_cost_ff);
   assign cost_sat = cost_sum[32] ? '1 : cost_sum[31:0];

   // beat offered by the port walk
   always_comb begin
      emit_data.port_index = cur_num[2:0];
      emit_data.root_id    = root_id_ff;
      emit_data.root_cost  = root_cost_ff;
      emit_data.bridge_id  = bridge_id_ff;
      emit_data.port_id    = own_id;
      emit_data.last       = 1'b0;
   end

   assign do_emit  = want_emit && may_send && (32'(emit_cnt_ff) < MAX_RESULTS);
   assign stall    = do_emit && pend_valid_ff && !out_free;
   assign push_out = (do_emit && !stall && pend_valid_ff) ||
                     (state_ff == ST_FINISH && pend_valid_ff && out_free);

   // sequencer: next state, memory writes, emit requests
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      wr_en     = 1'b0;
      wr_data   = rd_data_ff;
      want_emit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_beat) begin
               case (req_chan.kind)
                  KIND_START:  state_in = ST_START_WR;
                  KIND_TICK:   state_in = (hello_ff && may_send) ? ST_TICK_RD : ST_IDLE;
                  KIND_CONFIG: state_in = (32'(req_chan.port_index) < 32'(cnt)) ?
                                          ST_CFG_RD : ST_IDLE;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_START_WR: begin
            if (idx_ff < cnt) begin
               wr_en   = 1'b1;
               wr_data = '{root_id: bridge_id_ff, cost: '0,
                           bridge_id: bridge_id_ff, peer_id: own_id};
               idx_in  = idx_ff + 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK_RD: begin
            state_in = (idx_ff < cnt) ? ST_TICK_CHK : ST_FINISH;
         end
         ST_TICK_CHK: begin
            want_emit = designated;
            if (!stall) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_TICK_RD;
            end
         end
         ST_CFG_RD: begin
            state_in = ST_CFG_CHK;
         end
         ST_CFG_CHK: begin
            if (rd_better) begin
               // stored vector wins: answer on that port
               want_emit = 1'b1;
               if (!stall) begin
                  state_in = ST_FINISH;
               end
            end else begin
               wr_en    = 1'b1;
               wr_data  = rx_ff;
               idx_in   = '0;
               state_in = ST_ELECT_RD;
            end
         end
         ST_ELECT_RD: begin
            state_in = (idx_ff < cnt) ? ST_ELECT_CHK : ST_ROOT_SET;
         end
         ST_ELECT_CHK: begin
            idx_in   = idx_ff + 1'b1;
            state_in = ST_ELECT_RD;
         end
         ST_ROOT_SET: begin
            idx_in   = '0;
            state_in = ST_UPD_RD;
         end
         ST_UPD_RD: begin
            state_in = (idx_ff < cnt) ? ST_UPD_CHK : ST_FINISH;
         end
         ST_UPD_CHK: begin
            want_emit = designated || upd_take;
            if (!stall) begin
               if (designated) begin
                  wr_en           = 1'b1;
                  wr_data.root_id = root_id_ff;
                  wr_data.cost    = root_cost_ff;
               end else if (upd_take) begin
                  wr_en   = 1'b1;
                  wr_data = '{root_id: root_id_ff, cost: root_cost_ff,
                              bridge_id: bridge_id_ff, peer_id: own_id};
               end
               idx_in   = idx_ff + 1'b1;
               state_in = ST_UPD_RD;
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   // memory: one port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         port_mem[mem_addr] <= wr_data;
      end
      rd_data_ff <= port_mem[mem_addr];
   end

   // item capture
   always_ff @(posedge clock) begin
      if (req_beat) begin
         kind_ff    <= req_chan.kind;
         rx_port_ff <= req_chan.port_index;
         rx_ff      <= '{root_id: req_chan.rx_root_id, cost: req_chan.rx_root_cost,
                         bridge_id: req_chan.rx_bridge_id, peer_id: req_chan.rx_port_id};
      end
   end

   // election best-so-far
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (state_ff == ST_CFG_CHK) begin
         found_ff <= 1'b0;
      end else if (state_ff == ST_ELECT_CHK && !designated && (!found_ff || rd_better)) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_ELECT_CHK && !designated && (!found_ff || rd_better)) begin
         best_ff <= rd_data_ff;
      end
   end

   // bridge root state and hello flag
   always_ff @(posedge clock) begin
      if (reset) begin
         root_id_ff         <= '0;
         root_cost_ff       <= '0;
         root_port_valid_ff <= 1'b0;
         hello_ff           <= 1'b0;
      end else if (req_beat && req_chan.kind == KIND_START) begin
         root_id_ff         <= bridge_id_ff;
         root_cost_ff       <= '0;
         root_port_valid_ff <= 1'b0;
         hello_ff           <= 1'b1;
      end else if (state_ff == ST_ROOT_SET && kind_ff == KIND_CONFIG) begin
         hello_ff <= 1'b0;
         if (found_ff) begin
            root_id_ff         <= best_ff.root_id;
            root_cost_ff       <= cost_sat;
            root_port_valid_ff <= 1'b1;
         end else begin
            root_id_ff         <= bridge_id_ff;
            root_cost_ff       <= '0;
            root_port_valid_ff <= 1'b0;
         end
      end
   end

   // pending beat and emit count
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         emit_cnt_ff   <= '0;
      end else if (req_beat) begin
         emit_cnt_ff <= '0;
      end else if (do_emit && !stall) begin
         pend_valid_ff <= 1'b1;
         emit_cnt_ff   <= emit_cnt_ff + 1'b1;
      end else if (push_out) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_emit && !stall) begin
         pend_ff <= emit_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (push_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_out) begin
         out_ff      <= pend_ff;
         out_ff.last <= (state_ff == ST_FINISH);
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.tx_port_index = out_ff.port_index;
   assign rsp_chan.tx_root_id    = out_ff.root_id;
   assign rsp_chan.tx_root_cost  = out_ff.root_cost;
   assign rsp_chan.tx_bridge_id  = out_ff.bridge_id;
   assign rsp_chan.tx_port_id    = out_ff.port_id;
   assign rsp_chan.last          = out_ff.last;

`ifndef ASSERT_OFF
   a_emit_cap: assert property (@(posedge clock) disable iff (reset)
      32'(emit_cnt_ff) <= MAX_RESULTS)
      else $error("more beats than allowed for one item");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending beat left behind at idle");

   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START_WR) |-> !push_out)
      else $error("start item produced a beat");

   a_root_port: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT_SET) |=> (root_port_valid_ff == $past(found_ff)))
      else $error("root port flag does not follow election");
`endif

endmodule
